// ----- rtl/stpq_pkg.sv -----
package stpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int NUM_LEVELS   = 3;
    localparam int TAG_W        = 16;
    localparam int AGE_W        = 8;
    localparam int DATA_W       = TAG_W + AGE_W;
    localparam int LEVEL_W      = 2;
    localparam int REQ_W        = 3;
    localparam int OCC_W        = 5;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_LEVEL = 2'd3
    } status_t;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

endpackage

// ----- rtl/stpq_mem.sv -----
module stpq_mem
    import stpq_pkg::*;
#(
    parameter int DEPTH  = NUM_LEVELS * CAPACITY_DEF,
    parameter int ADDR_W = $clog2(NUM_LEVELS * CAPACITY_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stpq_ctrl.sv -----
module stpq_ctrl
    import stpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(NUM_LEVELS * CAPACITY_DEF)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [REQ_W-1:0]   priority_req,
    input  logic [TAG_W-1:0]   record_tag,
    input  logic [AGE_W-1:0]   age,
    output logic               done,
    output logic [1:0]         status,
    output logic               out_valid,
    output logic [LEVEL_W-1:0] out_priority,
    output logic [TAG_W-1:0]   out_tag,
    output logic [AGE_W-1:0]   out_age,
    output logic [OCC_W-1:0]   occupancy,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_waddr,
    output logic [DATA_W-1:0]  mem_wdata,
    output logic               mem_re,
    output logic [ADDR_W-1:0]  mem_raddr,
    input  logic [DATA_W-1:0]  mem_rdata
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   head_next [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]   lcnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0]   lcnt_next [NUM_LEVELS];
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [LEVEL_W-1:0] pop_lvl_reg, pop_lvl_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic               valid_reg, valid_next;
    logic [LEVEL_W-1:0] prio_reg, prio_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    logic               accept;
    logic               level_ok;
    logic               full;
    logic               empty;
    logic [LEVEL_W-1:0] push_idx;
    logic [LEVEL_W-1:0] pop_idx;

    assign accept   = start && (state_reg == S_IDLE);
    assign level_ok = (priority_req != '0) && !priority_req[REQ_W-1];
    assign full     = (total_reg == CNT_W'(CAPACITY));
    assign empty    = (total_reg == '0);
    assign push_idx = priority_req[LEVEL_W-1:0] - 1'b1;

    // highest non-empty level
    always_comb
    begin
        if (lcnt_reg[2] != '0)
        begin
            pop_idx = 2'd2;
        end
        else if (lcnt_reg[1] != '0)
        begin
            pop_idx = 2'd1;
        end
        else
        begin
            pop_idx = 2'd0;
        end
    end

    assign mem_waddr = ADDR_W'(push_idx) * ADDR_W'(CAPACITY) + ADDR_W'(tail_reg[push_idx]);
    assign mem_raddr = ADDR_W'(pop_idx) * ADDR_W'(CAPACITY) + ADDR_W'(head_reg[pop_idx]);
    assign mem_wdata = {record_tag, age};

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        lcnt_next    = lcnt_reg;
        total_next   = total_reg;
        pop_lvl_next = pop_lvl_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        tag_next     = tag_reg;
        age_next     = age_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    valid_next = 1'b0;
                    prio_next  = '0;
                    tag_next   = '0;
                    age_next   = '0;
                    if (mode == MODE_POP)
                    begin
                        if (empty)
                        begin
                            status_next = STAT_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            pop_lvl_next = pop_idx + 1'b1;
                            head_next[pop_idx] = (head_reg[pop_idx] == PTR_W'(CAPACITY - 1))
                                ? '0 : head_reg[pop_idx] + 1'b1;
                            lcnt_next[pop_idx] = lcnt_reg[pop_idx] - 1'b1;
                            total_next = total_reg - 1'b1;
                            state_next = S_POP;
                        end
                    end
                    else if (!level_ok)
                    begin
                        status_next = STAT_BAD_LEVEL;
                        done_next   = 1'b1;
                    end
                    else if (full)
                    begin
                        status_next = STAT_FULL;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        tail_next[push_idx] = (tail_reg[push_idx] == PTR_W'(CAPACITY - 1))
                            ? '0 : tail_reg[push_idx] + 1'b1;
                        lcnt_next[push_idx] = lcnt_reg[push_idx] + 1'b1;
                        total_next  = total_reg + 1'b1;
                        status_next = STAT_OK;
                        done_next   = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                status_next = STAT_OK;
                valid_next  = 1'b1;
                prio_next   = pop_lvl_reg;
                tag_next    = mem_rdata[DATA_W-1:AGE_W];
                age_next    = mem_rdata[AGE_W-1:0];
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        occ_next = OCC_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            total_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                lcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            total_reg <= total_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            lcnt_reg  <= lcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_lvl_reg <= pop_lvl_next;
        status_reg  <= status_next;
        valid_reg   <= valid_next;
        prio_reg    <= prio_next;
        tag_reg     <= tag_next;
        age_reg     <= age_next;
        occ_reg     <= occ_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_valid    = valid_reg;
    assign out_priority = prio_reg;
    assign out_tag      = tag_reg;
    assign out_age      = age_reg;
    assign occupancy    = occ_reg;

endmodule

// ----- rtl/stable_three_level_priority_queue.sv -----
// stable three-level priority queue: a push (mode 0) stores an entry at level 1 to 3 behind all
// entries of equal or higher level, a pop (mode 1) returns the oldest entry of the highest level
// held. an item transfers at the rising edge where start is high and busy is low. every item
// gives exactly one result, shown for one cycle with done high; the receiver cannot stall it, so
// it must take the result on that cycle. a push, a refused push and a pop on empty leave busy
// low, so a new item can follow on the next edge, and the result is registered at the transfer
// edge and shows in the next cycle. a pop that returns an entry waits on the registered read of
// the entry memory: busy is high for one cycle, the entry is first registered in the memory's
// read register and then in the result registers. no clearing pass is needed after reset.
module stable_three_level_priority_queue
    import stpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [REQ_W-1:0]   priority_req,
    input  logic [TAG_W-1:0]   record_tag,
    input  logic [AGE_W-1:0]   age,
    output logic               done,
    output logic [1:0]         status,
    output logic               out_valid,
    output logic [LEVEL_W-1:0] out_priority,
    output logic [TAG_W-1:0]   out_tag,
    output logic [AGE_W-1:0]   out_age,
    output logic [OCC_W-1:0]   occupancy
);

    // one circular buffer per level, each CAPACITY deep, packed into one memory;
    // the level itself is implied by which buffer holds the entry
    localparam int DEPTH  = NUM_LEVELS * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // pointers, per-level counts, total count and result registers
    stpq_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .priority_req (priority_req),
        .record_tag   (record_tag),
        .age          (age),
        .done         (done),
        .status       (status),
        .out_valid    (out_valid),
        .out_priority (out_priority),
        .out_tag      (out_tag),
        .out_age      (out_age),
        .occupancy    (occupancy),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // tag and age storage, registered read
    stpq_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
